[hw/rtl/b64_pkg.sv]
// ----------------------------------------------------------------------------
// b64_pkg
// shared types, character codes and alphabet helpers for the base64 codec
// ----------------------------------------------------------------------------
package b64_pkg;

    // special characters
    localparam logic [7:0] PAD_CHAR = 8'd61;
    localparam logic [7:0] LF_CHAR  = 8'd10;
    localparam logic [7:0] CR_CHAR  = 8'd13;

    // results per request at most
    localparam int unsigned MAX_RESULTS = 4;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one result item
    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       eom;
        logic       bad;
        logic       last;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_group_t;

    // sextet to alphabet character
    function automatic logic [7:0] sextet_char(input logic [5:0] k);
        logic [7:0] kx;
        kx = {2'b00, k};
        if (k < 6'd26)
            return kx + 8'd65;
        else if (k < 6'd52)
            return kx + 8'd71;
        else if (k < 6'd62)
            return kx - 8'd4;
        else if (k == 6'd62)
            return 8'd43;
        else
            return 8'd47;
    endfunction

    // alphabet character to sextet, msb set when outside the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c inside {[8'd65:8'd90]})
            return {1'b0, 6'(c - 8'd65)};
        else if (c inside {[8'd97:8'd122]})
            return {1'b0, 6'(c - 8'd71)};
        else if (c inside {[8'd48:8'd57]})
            return {1'b0, 6'(c + 8'd4)};
        else if (c == 8'd43)
            return {1'b0, 6'd62};
        else if (c == 8'd47)
            return {1'b0, 6'd63};
        else
            return {1'b1, 6'd0};
    endfunction

endpackage

[hw/rtl/b64_core.sv]
// ----------------------------------------------------------------------------
// b64_core
// codec state and the single-pass logic that turns one request into a
// group of up to four results
// ----------------------------------------------------------------------------
module b64_core
    import b64_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          direction,
    input  logic          take,
    input  logic [7:0]    item_value,
    input  logic          item_last,
    output result_group_t group,
    output logic [2:0]    group_num
);

    logic [1:0]  group_count_reg, group_count_next;
    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [11:0] bit_acc_reg, bit_acc_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic        error_reg, error_next;

    logic [23:0] enc_word;
    logic [2:0]  enc_chars;
    logic [6:0]  sext;
    logic [3:0]  bc_sum;
    logic [2:0]  bc_rem;
    logic [11:0] acc_new;
    logic [5:0]  enc_sextet [MAX_RESULTS];

    // result group and next state
    always_comb
    begin
        group            = '0;
        group_num        = 3'd0;
        group_count_next = group_count_reg;
        held_bytes_next  = held_bytes_reg;
        bit_acc_next     = bit_acc_reg;
        bit_count_next   = bit_count_reg;
        error_next       = error_reg;
        enc_word         = '0;
        enc_chars        = 3'd0;
        sext             = char_sextet(item_value);
        acc_new          = {bit_acc_reg[5:0], sext[5:0]};
        bc_sum           = {1'b0, bit_count_reg} + 4'd6;
        bc_rem           = 3'(bc_sum - 4'd8);
        for (int k = 0; k < MAX_RESULTS; k++)
            enc_sextet[k] = 6'd0;

        if (direction == DIR_ENCODE)
        begin
            // encode: gather three bytes, flush a partial group at the end
            if (group_count_reg[1])
            begin
                enc_word  = {held_bytes_reg, item_value};
                enc_chars = 3'd4;
            end
            else if (!item_last)
            begin
                held_bytes_next  = {held_bytes_reg[7:0], item_value};
                group_count_next = group_count_reg + 2'd1;
            end
            else if (group_count_reg == 2'd1)
            begin
                enc_word  = {held_bytes_reg[7:0], item_value, 8'd0};
                enc_chars = 3'd3;
            end
            else
            begin
                enc_word  = {item_value, 16'd0};
                enc_chars = 3'd2;
            end
            if (enc_chars != 3'd0)
            begin
                enc_sextet[0] = enc_word[23:18];
                enc_sextet[1] = enc_word[17:12];
                enc_sextet[2] = enc_word[11:6];
                enc_sextet[3] = enc_word[5:0];
                for (int k = 0; k < MAX_RESULTS; k++)
                begin
                    group[k].value = (3'(k) < enc_chars) ? sextet_char(enc_sextet[k])
                                                         : PAD_CHAR;
                    group[k].valid = 1'b1;
                end
                group[MAX_RESULTS-1].eom = item_last;
                group_num        = 3'd4;
                group_count_next = 2'd0;
                held_bytes_next  = 16'd0;
            end
        end
        else
        begin
            // decode: skip pad and line breaks, flag characters outside the alphabet, shift sextets in
            if (error_reg)
            begin
                if (item_last)
                begin
                    group[0].eom = 1'b1;
                    group[0].bad = 1'b1;
                    group_num    = 3'd1;
                end
            end
            else if (item_value == PAD_CHAR || item_value == LF_CHAR
                     || item_value == CR_CHAR)
            begin
                if (item_last)
                begin
                    group[0].eom = 1'b1;
                    group_num    = 3'd1;
                end
            end
            else if (sext[6])
            begin
                error_next   = 1'b1;
                group[0].eom = item_last;
                group[0].bad = 1'b1;
                group_num    = 3'd1;
            end
            else
            begin
                bit_acc_next = acc_new;
                if (bc_sum[3])
                begin
                    bit_count_next = bc_rem;
                    group[0].value = 8'(acc_new >> bc_rem);
                    group[0].valid = 1'b1;
                    group[0].eom   = item_last;
                    group_num      = 3'd1;
                end
                else
                begin
                    bit_count_next = bc_sum[2:0];
                    if (item_last)
                    begin
                        group[0].eom = 1'b1;
                        group_num    = 3'd1;
                    end
                end
            end
        end

        // mark the last result of this request
        if (group_num != 3'd0)
            group[2'(group_num - 3'd1)].last = 1'b1;

        // message end clears all codec state
        if (item_last)
        begin
            group_count_next = 2'd0;
            held_bytes_next  = 16'd0;
            bit_acc_next     = 12'd0;
            bit_count_next   = 3'd0;
            error_next       = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= 2'd0;
            held_bytes_reg  <= 16'd0;
            bit_acc_reg     <= 12'd0;
            bit_count_reg   <= 3'd0;
            error_reg       <= 1'b0;
        end
        else if (take)
        begin
            group_count_reg <= group_count_next;
            held_bytes_reg  <= held_bytes_next;
            bit_acc_reg     <= bit_acc_next;
            bit_count_reg   <= bit_count_next;
            error_reg       <= error_next;
        end
    end

endmodule

[hw/rtl/b64_out_buf.sv]
// ----------------------------------------------------------------------------
// b64_out_buf
// result register holding one group, shifted out one result per cycle while take is high
// ----------------------------------------------------------------------------
module b64_out_buf
    import b64_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_group_t load_group,
    input  logic [2:0]    load_num,
    input  logic          take,
    output logic          free,
    output logic          head_valid,
    output result_t       head
);

    result_group_t entries_reg;
    logic [2:0]    remain_reg;
    logic          pop;

    // head of the group and load condition
    assign head_valid = (remain_reg != 3'd0);
    assign head       = entries_reg[0];
    assign pop        = head_valid && take;
    assign free       = (remain_reg == 3'd0) || (remain_reg == 3'd1 && pop);

    // remaining count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remain_reg <= 3'd0;
        else if (load)
            remain_reg <= load_num;
        else if (pop)
            remain_reg <= remain_reg - 3'd1;
    end

    // result entries
    always_ff @(posedge clk)
    begin
        if (load)
            entries_reg <= load_group;
        else if (pop)
        begin
            for (int k = 0; k < MAX_RESULTS - 1; k++)
                entries_reg[k] <= entries_reg[k+1];
            entries_reg[MAX_RESULTS-1] <= '0;
        end
    end

endmodule

[hw/rtl/base64_stream_codec_unit.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// streaming base64 codec, direction register selects encode or decode
// ----------------------------------------------------------------------------
// path: a request is held in the input register, then its results in the result register
// throughput: decode takes one request per cycle while the results are taken; a request
//   waits in the input register while a group shifts out, so back to back the next encode
//   group's first byte enters as the last character of the group before it shifts out
// reset: asynchronous active low, clears direction, codec state and all valids
module base64_stream_codec_unit
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_value,
    input  logic       message_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_value,
    output logic       value_valid,
    output logic       end_of_message,
    output logic       bad_char,
    output logic       run_last
);

    logic          direction_reg;
    logic          in_full_reg;
    logic [7:0]    in_value_reg;
    logic          in_last_reg;
    logic          consume;
    logic          buf_free;
    result_group_t group;
    logic [2:0]    group_num;
    result_t       head;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= DIR_ENCODE;
        else if (cfg_write_en)
            direction_reg <= cfg_write_data;
    end

    // input register
    assign consume  = in_full_reg && buf_free;
    assign in_ready = !in_full_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_ready)
            in_full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_value_reg <= in_value;
            in_last_reg  <= message_end;
        end
    end

    // codec logic
    b64_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .direction  (direction_reg),
        .take       (consume),
        .item_value (in_value_reg),
        .item_last  (in_last_reg),
        .group      (group),
        .group_num  (group_num)
    );

    // result register
    b64_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume),
        .load_group (group),
        .load_num   (group_num),
        .take       (out_ready),
        .free       (buf_free),
        .head_valid (out_valid),
        .head       (head)
    );

    // result fields
    assign out_value      = head.value;
    assign value_valid    = head.valid;
    assign end_of_message = head.eom;
    assign bad_char       = head.bad;
    assign run_last       = head.last;

endmodule

[sim/tb_base64_stream_codec_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_codec_unit
// self-checking bench for the base64 codec: a behavioral codec model predicts
// every result from the accepted requests; directed messages cover padding,
// skipped and invalid characters, then random encode and decode phases run
// with random idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module tb_base64_stream_codec_unit
    import b64_pkg::*;
;

    localparam int PHASE_ITEMS    = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PRESSURE_PHASE = 2;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] value;
        logic       eom;
    } stream_item_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_write_en   = 1'b0;
    logic       cfg_write_data = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] in_value       = '0;
    logic       message_end    = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [7:0] out_value;
    logic       value_valid;
    logic       end_of_message;
    logic       bad_char;
    logic       run_last;

    // stimulus and checking state
    stream_item_t stream_in_queue [$];
    result_t      predicted_out [$];
    int           mismatch_count = 0;
    bit           send_idle_on   = 1'b0;
    bit           recv_idle_on   = 1'b0;
    bit           hold_req       = 1'b0;
    bit           hold_seen      = 1'b0;
    int           send_gap       = 0;
    int           recv_gap       = 0;
    int           hold_left      = 0;
    int           stall_cycles   = 0;

    // codec model state
    logic         model_dir = DIR_ENCODE;
    logic [1:0]   enc_count = '0;
    logic [15:0]  enc_held  = '0;
    logic [11:0]  dec_acc   = '0;
    int           dec_bits  = 0;
    logic         dec_err   = 1'b0;

    base64_stream_codec_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_value       (in_value),
        .message_end    (message_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_value      (out_value),
        .value_valid    (value_valid),
        .end_of_message (end_of_message),
        .bad_char       (bad_char),
        .run_last       (run_last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] alphabet_char(input logic [5:0] k);
        return ALPHABET[8*(63 - int'(k)) +: 8];
    endfunction

    // -1 for anything outside the alphabet
    function automatic int sextet_value(input logic [7:0] c);
        for (int k = 0; k < 64; k++)
        begin
            if (alphabet_char(6'(k)) == c)
                return k;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // expected results of one accepted request
    task automatic base64_predict(input logic [7:0] v, input logic eom_in);
        result_t     grp [MAX_RESULTS];
        int          n;
        int          chars;
        int          sx;
        logic [23:0] word;
        n     = 0;
        chars = 0;
        word  = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
            grp[k] = '0;
        if (model_dir == DIR_ENCODE)
        begin
            // gather bytes, a full group or a message end emits four characters
            if (enc_count == 2'd2)
            begin
                word  = {enc_held, v};
                chars = 4;
            end
            else if (!eom_in)
            begin
                enc_held  = {enc_held[7:0], v};
                enc_count = enc_count + 2'd1;
            end
            else if (enc_count == 2'd1)
            begin
                word  = {enc_held[7:0], v, 8'h00};
                chars = 3;
            end
            else
            begin
                word  = {v, 16'h0000};
                chars = 2;
            end
            if (chars != 0)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    grp[k].value = (k < chars) ? alphabet_char(word[18 - 6*k +: 6])
                                               : PAD_CHAR;
                    grp[k].valid = 1'b1;
                    grp[k].eom   = eom_in && (k == 3);
                end
                n         = 4;
                enc_count = '0;
                enc_held  = '0;
            end
        end
        else if (dec_err)
        begin
            // error latched, only the message end answers
            if (eom_in)
            begin
                grp[0].eom = 1'b1;
                grp[0].bad = 1'b1;
                n          = 1;
            end
        end
        else if (v == PAD_CHAR || v == LF_CHAR || v == CR_CHAR)
        begin
            if (eom_in)
            begin
                grp[0].eom = 1'b1;
                n          = 1;
            end
        end
        else
        begin
            sx = sextet_value(v);
            if (sx < 0)
            begin
                dec_err    = 1'b1;
                grp[0].eom = eom_in;
                grp[0].bad = 1'b1;
                n          = 1;
            end
            else
            begin
                dec_acc  = {dec_acc[5:0], 6'(sx)};
                dec_bits = dec_bits + 6;
                if (dec_bits >= 8)
                begin
                    dec_bits     = dec_bits - 8;
                    grp[0].value = 8'(dec_acc >> dec_bits);
                    grp[0].valid = 1'b1;
                    grp[0].eom   = eom_in;
                    n            = 1;
                end
                else if (eom_in)
                begin
                    grp[0].eom = 1'b1;
                    n          = 1;
                end
            end
        end
        // message end clears both encode and decode state
        if (eom_in)
        begin
            enc_count = '0;
            enc_held  = '0;
            dec_acc   = '0;
            dec_bits  = 0;
            dec_err   = 1'b0;
        end
        if (n > 0)
            grp[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            predicted_out = {predicted_out, grp[k]};
    endtask

    task automatic push_request(input logic [7:0] v, input logic eom_in);
        stream_item_t item;
        item.value = v;
        item.eom   = eom_in;
        stream_in_queue = {stream_in_queue, item};
    endtask

    // one text message, optionally with an invalid character somewhere
    task automatic queue_text_message(input bit broken);
        logic [7:0] text [$];
        logic [7:0] c;
        int         len;
        int         bad_at;
        len    = $urandom_range(1, 12);
        bad_at = broken ? int'($urandom_range(0, len - 1)) : -1;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                text = {text, ($urandom_range(0, 1) ? LF_CHAR : CR_CHAR)};
            if (i == bad_at)
            begin
                c = 8'($urandom_range(0, 255));
                while (sextet_value(c) >= 0 || c == PAD_CHAR || c == LF_CHAR ||
                       c == CR_CHAR)
                    c = 8'($urandom_range(0, 255));
            end
            else
                c = alphabet_char(6'($urandom_range(0, 63)));
            text = {text, c};
        end
        if (len % 4 == 2)
        begin
            text = {text, PAD_CHAR};
            text = {text, PAD_CHAR};
        end
        else if (len % 4 == 3)
            text = {text, PAD_CHAR};
        if ($urandom_range(0, 7) == 0)
            text = {text, LF_CHAR};
        foreach (text[i])
            push_request(text[i], i == text.size() - 1);
    endtask

    task automatic write_direction(input logic d);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= d;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // all requests taken, all results seen, then let the pipeline settle
    task automatic wait_drained();
        @(negedge clk);
        while (stream_in_queue.size() != 0 || in_valid || predicted_out.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        stream_item_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            in_value    <= '0;
            message_end <= 1'b0;
            send_gap    <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (stream_in_queue.size() != 0)
            begin
                nxt         = stream_in_queue.pop_front();
                in_valid    <= 1'b1;
                in_value    <= nxt.value;
                message_end <= nxt.eom;
                send_gap    <= send_idle_on ? int'($urandom_range(0, 17)) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink with random stalls and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int nxt_gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (out_ready)
        begin
            if (out_valid)
            begin
                nxt_gap   = recv_idle_on ? int'($urandom_range(0, 17)) : 0;
                recv_gap  <= nxt_gap;
                out_ready <= (nxt_gap == 0);
            end
        end
        else if (recv_gap > 1)
            recv_gap <= recv_gap - 1;
        else
        begin
            recv_gap  <= 0;
            out_ready <= 1'b1;
        end
    end

    // result check, register tracking and prediction
    always @(posedge clk)
    begin : codec_monitor
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_out.size() == 0)
                    report_mismatch("result with nothing expected", out_value, 8'h00);
                else
                begin
                    want = predicted_out.pop_front();
                    if (out_value !== want.value)
                        report_mismatch("out_value", out_value, want.value);
                    if (value_valid !== want.valid)
                        report_mismatch("value_valid", 8'(value_valid), 8'(want.valid));
                    if (end_of_message !== want.eom)
                        report_mismatch("end_of_message", 8'(end_of_message),
                                        8'(want.eom));
                    if (bad_char !== want.bad)
                        report_mismatch("bad_char", 8'(bad_char), 8'(want.bad));
                    if (run_last !== want.last)
                        report_mismatch("run_last", 8'(run_last), 8'(want.last));
                end
            end
            if (cfg_write_en)
                model_dir = cfg_write_data;
            if (in_valid && in_ready)
                base64_predict(in_value, message_end);
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed encode: lone byte, group plus two-byte flush,
        // group ending the message, then one byte left held
        write_direction(DIR_ENCODE);
        @(negedge clk);
        push_request(8'h00, 1'b1);
        push_request(8'hFF, 1'b0);
        push_request(8'h00, 1'b0);
        push_request(8'h80, 1'b0);
        push_request(8'h01, 1'b0);
        push_request(8'h7F, 1'b1);
        push_request(8'h00, 1'b0);
        push_request(8'h80, 1'b0);
        push_request(8'hFF, 1'b1);
        push_request(8'hAA, 1'b0);
        wait_drained();

        // directed decode: skips, pad at the end, short tail, invalid
        // characters mid message and at the end, byte on the last character
        write_direction(DIR_DECODE);
        @(negedge clk);
        push_request("T", 1'b0);
        push_request("W", 1'b0);
        push_request(LF_CHAR, 1'b0);
        push_request("F", 1'b0);
        push_request(CR_CHAR, 1'b0);
        push_request("u", 1'b0);
        push_request(PAD_CHAR, 1'b1);
        push_request("A", 1'b1);
        push_request("Q", 1'b0);
        push_request("!", 1'b0);
        push_request("Q", 1'b0);
        push_request("A", 1'b1);
        push_request("*", 1'b1);
        push_request("/", 1'b0);
        push_request("+", 1'b1);
        wait_drained();

        // random phases, alternating direction so held state carries over
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_direction((p % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            @(negedge clk);
            send_idle_on = (p == 0 || p == PRESSURE_PHASE) ? 1'b0
                                                           : ($urandom_range(0, 3) != 0);
            recv_idle_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == PRESSURE_PHASE)
                hold_req = ~hold_req;
            if (p % 2 == 0)
            begin
                while (stream_in_queue.size() < PHASE_ITEMS)
                    push_request(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            end
            else
            begin
                while (stream_in_queue.size() < PHASE_ITEMS)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 7)
                        queue_text_message(1'b0);
                    else if (r == 7)
                        queue_text_message(1'b1);
                    else
                    begin
                        repeat ($urandom_range(1, 6))
                            push_request(8'($urandom_range(0, 255)),
                                         $urandom_range(0, 3) == 0);
                    end
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
hw/rtl/b64_pkg.sv
hw/rtl/b64_core.sv
hw/rtl/b64_out_buf.sv
hw/rtl/base64_stream_codec_unit.sv
sim/tb_base64_stream_codec_unit.sv
